// File: rtl/core/tws_pkg.sv
package tws_pkg;

    localparam int RING_DEPTH_DEF = 64;
    localparam int DATA_W         = 32;
    localparam int SUM_OUT_W      = 38;
    localparam int USED_OUT_W     = 7;
    localparam int IN_TDATA_W     = 64;
    localparam int OUT_TDATA_W    = 88;

    localparam logic [DATA_W-1:0] WINDOW_RESET = 32'd1000;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_START = 4'b0010,
        ST_WALK  = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    typedef struct packed {
        logic accept;
        logic advance;
        logic add;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic cont;
        logic out_free;
    } status_t;

endpackage

// File: rtl/core/tws_ctrl.sv
module tws_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  tws_pkg::status_t status,
    output tws_pkg::cmd_t    cmd
);

    tws_pkg::state_t state_reg;
    tws_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tws_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        unique case (state_reg)
            tws_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = tws_pkg::ST_START;
                end
            end
            tws_pkg::ST_START:
            begin
                cmd.advance = 1'b1;
                state_next  = tws_pkg::ST_WALK;
            end
            tws_pkg::ST_WALK:
            begin
                if (status.cont)
                begin
                    cmd.add     = 1'b1;
                    cmd.advance = 1'b1;
                end
                else
                begin
                    state_next = tws_pkg::ST_DONE;
                end
            end
            tws_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = tws_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tws_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/tws_datapath.sv
module tws_datapath #(
    parameter int RING_DEPTH = tws_pkg::RING_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tws_pkg::cmd_t                      cmd,
    output tws_pkg::status_t                   status,
    input  logic [tws_pkg::IN_TDATA_W-1:0]     in_data,
    input  logic                               cfg_valid,
    input  logic [tws_pkg::DATA_W-1:0]         cfg_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [tws_pkg::OUT_TDATA_W-1:0]    out_data
);

    localparam int SLOT_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W   = $clog2(RING_DEPTH + 1);
    localparam int GROW_W  = tws_pkg::DATA_W + CNT_W;
    localparam int SUM_W   = (GROW_W > tws_pkg::SUM_OUT_W) ? GROW_W : tws_pkg::SUM_OUT_W;
    localparam int UEXT_W  = (CNT_W > tws_pkg::USED_OUT_W) ? CNT_W : tws_pkg::USED_OUT_W;
    localparam int PAD_W   = tws_pkg::OUT_TDATA_W - 2 * tws_pkg::SUM_OUT_W
                             - tws_pkg::USED_OUT_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(RING_DEPTH);

    logic [tws_pkg::IN_TDATA_W-1:0] ring_mem [RING_DEPTH];

    logic [tws_pkg::DATA_W-1:0]     window_reg;
    logic [SLOT_W-1:0]              newest_reg;
    logic [CNT_W-1:0]               count_reg;
    logic [SLOT_W-1:0]              rd_slot_reg;
    logic [tws_pkg::IN_TDATA_W-1:0] rd_data_reg;
    logic [CNT_W-1:0]               used_reg;
    logic [SUM_W-1:0]               bsum_reg;
    logic [SUM_W-1:0]               psum_reg;
    logic                           out_valid_reg;
    logic [tws_pkg::OUT_TDATA_W-1:0] out_data_reg;

    logic [SLOT_W-1:0]              slot_next;
    logic [SLOT_W-1:0]              rd_slot_next;
    logic [UEXT_W-1:0]              used_ext;

    always_comb
    begin
        if (count_reg == '0)
        begin
            slot_next = newest_reg;
        end
        else if (newest_reg == LAST_SLOT)
        begin
            slot_next = '0;
        end
        else
        begin
            slot_next = newest_reg + 1'b1;
        end
        rd_slot_next = (rd_slot_reg == '0) ? LAST_SLOT : rd_slot_reg - 1'b1;
    end

    assign used_ext = UEXT_W'(used_reg);

    assign status.cont = (used_reg < count_reg)
                       && (psum_reg < SUM_W'(window_reg));
    assign status.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            ring_mem[slot_next] <= in_data;
        end
        rd_data_reg <= ring_mem[rd_slot_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= tws_pkg::WINDOW_RESET;
            newest_reg    <= '0;
            count_reg     <= '0;
            rd_slot_reg   <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                window_reg <= cfg_data;
            end
            if (cmd.accept)
            begin
                newest_reg  <= slot_next;
                rd_slot_reg <= slot_next;
                used_reg    <= '0;
                if (count_reg != FULL_CNT)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            else if (cmd.advance)
            begin
                rd_slot_reg <= rd_slot_next;
            end
            if (cmd.add)
            begin
                used_reg <= used_reg + 1'b1;
            end
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            bsum_reg <= '0;
            psum_reg <= '0;
        end
        else if (cmd.add)
        begin
            bsum_reg <= bsum_reg + SUM_W'(rd_data_reg[tws_pkg::DATA_W-1:0]);
            psum_reg <= psum_reg
                        + SUM_W'(rd_data_reg[tws_pkg::IN_TDATA_W-1:tws_pkg::DATA_W]);
        end
        if (cmd.load)
        begin
            out_data_reg <= {{PAD_W{1'b0}},
                             used_ext[tws_pkg::USED_OUT_W-1:0],
                             psum_reg[tws_pkg::SUM_OUT_W-1:0],
                             bsum_reg[tws_pkg::SUM_OUT_W-1:0]};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= count_reg)
        else $error("walk used more samples than stored");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("stored count beyond ring depth");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a pending result");

    a_add_on_cont: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.add |-> status.cont)
        else $error("sample added after walk end");

endmodule

// File: rtl/core/time_window_throughput_sum_top.sv
// Sliding time-window sum of acknowledgement samples. Each request on the
// slave side stores one sample (byte count and period) in a ring of the
// RING_DEPTH most recent samples, then walks backward from the newest one,
// one stored sample per cycle through the ring memory's single read port,
// until the period sum reaches window_period or the stored samples run out.
// Once the walk ends, the result goes into the output register as soon as
// the master side holds no earlier result, and the slave side is ready
// again as the result enters that register, so a request is taken only
// after the last one's result has been loaded; a new request is taken while an
// earlier result still waits on the master side.
// window_period resets to 1000; the user must write it through the cfg
// channel only while the block is idle, as the block does not enforce this.
module time_window_throughput_sum_top #(
    parameter int RING_DEPTH = tws_pkg::RING_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [31:0] byte_count, [63:32] sample_period
    input  logic [tws_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [37:0] byte_sum, [75:38] period_sum, [82:76] samples_used, [87:83] zero
    output logic [tws_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tws_pkg::DATA_W-1:0]      cfg_data
);

    tws_pkg::cmd_t    cmd;
    tws_pkg::status_t status;

    assign cfg_ready = 1'b1;

    tws_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tws_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_axis_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule
